// ===== rtl/csip_pkg.sv =====
// csip_pkg: shared codes, byte constants and result type for the CSI parser
// no dependencies; imported by all parser modules and the checker
package csip_pkg;

  localparam int BUFFER_SIZE_DEF = 16;

  // status codes
  localparam logic [1:0] ST_DISCARDED = 2'd0;
  localparam logic [1:0] ST_CONSUMED  = 2'd1;
  localparam logic [1:0] ST_COMPLETED = 2'd2;

  // key event codes
  localparam logic [2:0] KEY_UNDEFINED = 3'd0;
  localparam logic [2:0] KEY_UP        = 3'd1;
  localparam logic [2:0] KEY_DOWN      = 3'd2;
  localparam logic [2:0] KEY_RIGHT     = 3'd3;
  localparam logic [2:0] KEY_LEFT      = 3'd4;
  localparam logic [2:0] KEY_DELETE    = 3'd5;

  // byte constants
  localparam logic [7:0] CH_ESC       = 8'h1B;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_PARAM_LO  = 8'h20;
  localparam logic [7:0] CH_PARAM_HI  = 8'h3F;
  localparam logic [7:0] CH_FINAL_LO  = 8'h40;
  localparam logic [7:0] CH_FINAL_HI  = 8'h7E;
  localparam logic [7:0] CH_TILDE     = 8'h7E;
  localparam logic [7:0] CH_DIGIT3    = 8'h33;
  localparam logic [7:0] CH_UP        = 8'h41;
  localparam logic [7:0] CH_DOWN      = 8'h42;
  localparam logic [7:0] CH_RIGHT     = 8'h43;
  localparam logic [7:0] CH_LEFT      = 8'h44;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] key_event;
  } csip_result_t;

endpackage

// ===== rtl/csip_parser.sv =====
// csip_parser: sequence state (mode, count, last parameter byte) and the
// per-byte decode that yields one result; depends on csip_pkg
module csip_parser #(
  parameter int BUFFER_SIZE = csip_pkg::BUFFER_SIZE_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [7:0]            ch,
  output csip_pkg::csip_result_t result
);
  import csip_pkg::*;

  localparam int CntW = $clog2(BUFFER_SIZE - 1);
  localparam logic [CntW-1:0] CntMax = CntW'(BUFFER_SIZE - 2);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_ESC,
    MODE_CSI
  } mode_t;

  mode_t           mode, mode_next;
  logic [CntW-1:0] stored_count, stored_count_next;
  logic [7:0]      last_param_byte, last_param_byte_next;

  logic       is_param, is_final;
  logic [2:0] key_dec;

  assign is_param = (ch >= CH_PARAM_LO) && (ch <= CH_PARAM_HI);
  assign is_final = (ch >= CH_FINAL_LO) && (ch <= CH_FINAL_HI);

  always_comb begin
    case (ch)
      CH_UP:    key_dec = KEY_UP;
      CH_DOWN:  key_dec = KEY_DOWN;
      CH_RIGHT: key_dec = KEY_RIGHT;
      CH_LEFT:  key_dec = KEY_LEFT;
      default: begin
        if (ch == CH_TILDE && stored_count != '0 && last_param_byte == CH_DIGIT3) begin
          key_dec = KEY_DELETE;
        end else begin
          key_dec = KEY_UNDEFINED;
        end
      end
    endcase
  end

  always_comb begin
    mode_next            = MODE_IDLE;
    stored_count_next    = stored_count;
    last_param_byte_next = last_param_byte;
    result.status        = ST_DISCARDED;
    result.key_event     = KEY_UNDEFINED;
    if (ch == CH_ESC && mode == MODE_IDLE) begin
      stored_count_next = '0;
      mode_next         = MODE_ESC;
      result.status     = ST_CONSUMED;
    end else if (mode == MODE_ESC && ch == CH_LBRACKET) begin
      mode_next     = MODE_CSI;
      result.status = ST_CONSUMED;
    end else if (mode == MODE_CSI) begin
      if (is_param) begin
        // overflowing parameter bytes drop the sequence
        if (stored_count < CntMax) begin
          last_param_byte_next = ch;
          stored_count_next    = stored_count + 1'b1;
          mode_next            = MODE_CSI;
          result.status        = ST_CONSUMED;
        end
      end else if (is_final) begin
        result.key_event = key_dec;
        result.status    = ST_COMPLETED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_IDLE;
      stored_count    <= '0;
      last_param_byte <= '0;
    end else if (step) begin
      mode            <= mode_next;
      stored_count    <= stored_count_next;
      last_param_byte <= last_param_byte_next;
    end
  end

endmodule

// ===== rtl/csip_out_reg.sv =====
// csip_out_reg: result register with valid/ready toward the receiver
// depends on csip_pkg for the result type
module csip_out_reg (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  csip_pkg::csip_result_t result_in,
  output logic                  can_load,
  output logic                  out_valid,
  input  logic                  out_ready,
  output csip_pkg::csip_result_t result_out
);
  import csip_pkg::*;

  // a new beat may enter when the register is empty or draining this cycle
  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_out <= result_in;
    end
  end

endmodule

// ===== rtl/csi_escape_sequence_parser_core.sv =====
// csi_escape_sequence_parser_core: top level of the CSI escape sequence parser
// depends on csip_pkg, csip_parser and csip_out_reg
//
// Usage:
//   input channel  (in_valid/in_ready, ch): one terminal byte per beat
//   output channel (out_valid/out_ready, status, key_event): one result per
//   input byte, in order; key_event is meaningful when status is completed
//   output path: the result of an accepted byte is registered in the result
//   register, which drives the output
//   throughput: one byte per cycle; the single result register sets this,
//   and in_ready stays high while the receiver takes each result
//   receiver stall: the result register holds its beat and in_ready drops
//   until the beat is taken, so no result is lost or repeated
//   reset (rst, synchronous): parser goes idle with an empty parameter
//   count, the result register is emptied
//   BUFFER_SIZE: parameter bytes kept per sequence is BUFFER_SIZE-2
module csi_escape_sequence_parser_core #(
  parameter int BUFFER_SIZE = csip_pkg::BUFFER_SIZE_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] ch,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] status,
  output logic [2:0] key_event
);
  import csip_pkg::*;

  logic         accept;
  csip_result_t step_result;
  csip_result_t held_result;

  assign accept = in_valid && in_ready;

  csip_parser #(
    .BUFFER_SIZE(BUFFER_SIZE)
  ) u_parser (
    .clk    (clk),
    .rst    (rst),
    .step   (accept),
    .ch     (ch),
    .result (step_result)
  );

  csip_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .result_in  (step_result),
    .can_load   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result_out (held_result)
  );

  assign status    = held_result.status;
  assign key_event = held_result.key_event;

endmodule

// ===== rtl/csip_checker.sv =====
// csip_checker: port-level assertions for the CSI parser top level
// depends on csip_pkg; bound to csi_escape_sequence_parser_core below
module csip_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] ch,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] status,
  input logic [2:0] key_event
);
  import csip_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(key_event))
    else $error("result beat changed while stalled");

  // every accepted byte yields a result on the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted byte produced no result");

  // key event is zero unless a sequence completed, never an unused code
  a_key_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_COMPLETED || key_event == KEY_UNDEFINED) &&
                  key_event <= KEY_DELETE && status != 2'd3)
    else $error("bad status or key event");

  // a completed sequence leaves the parser idle, so an escape accepted while
  // that beat is the latest result starts a new sequence and is consumed
  a_esc_start: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && ch == CH_ESC && out_valid && status == ST_COMPLETED
    |=> status == ST_CONSUMED)
    else $error("escape after completed sequence not consumed");

  // the input is never blocked while the result register is empty
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

bind csi_escape_sequence_parser_core csip_checker u_csip_checker (.*);

// ===== verif/csi_escape_sequence_parser_core_tb.sv =====
// csi_escape_sequence_parser_core_tb: self-checking bench for the CSI escape sequence parser
// directed byte table then random well-formed and broken sequences, each beat scored
// against a cycle-free parser model; depends on csip_pkg and csi_escape_sequence_parser_core
`timescale 1ns / 100ps

module csi_escape_sequence_parser_core_tb;
  import csip_pkg::*;

  localparam int MAX_PARAMS   = BUFFER_SIZE_DEF - 2;
  localparam int RANDOM_ITEMS = 1100;

  typedef enum logic [1:0] {SEEK_IDLE, SEEK_ESC, SEEK_CSI} seek_mode_t;

  typedef struct packed {
    logic [7:0] b;
    logic       pinned;
    logic [1:0] st;
    logic [2:0] key;
  } dir_row_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] ch;
  logic       out_valid;
  logic       out_ready;
  logic [1:0] status;
  logic [2:0] key_event;

  csi_escape_sequence_parser_core #(
    .BUFFER_SIZE(BUFFER_SIZE_DEF)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .ch(ch),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .key_event(key_event)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // parser shadow state
  seek_mode_t   seq_mode;
  int           param_cnt;
  logic [7:0]   last_param;

  csip_result_t pending_results[$];
  int           mismatches;
  int           fed_items;
  bit           valid_up;
  bit           feed_calm;
  dir_row_t     dir_rows[$];

  function automatic csip_result_t parse_byte(input logic [7:0] b);
    csip_result_t r;
    r.status    = ST_DISCARDED;
    r.key_event = KEY_UNDEFINED;
    if (b == CH_ESC && seq_mode == SEEK_IDLE) begin
      param_cnt = 0;
      seq_mode  = SEEK_ESC;
      r.status  = ST_CONSUMED;
    end else if (seq_mode == SEEK_ESC && b == CH_LBRACKET) begin
      seq_mode = SEEK_CSI;
      r.status = ST_CONSUMED;
    end else if (seq_mode == SEEK_CSI) begin
      if (b >= CH_PARAM_LO && b <= CH_PARAM_HI) begin
        if (param_cnt < MAX_PARAMS) begin
          last_param = b;
          param_cnt++;
          r.status = ST_CONSUMED;
        end else begin
          seq_mode = SEEK_IDLE;
        end
      end else if (b >= CH_FINAL_LO && b <= CH_FINAL_HI) begin
        r.status = ST_COMPLETED;
        case (b)
          CH_UP:    r.key_event = KEY_UP;
          CH_DOWN:  r.key_event = KEY_DOWN;
          CH_RIGHT: r.key_event = KEY_RIGHT;
          CH_LEFT:  r.key_event = KEY_LEFT;
          default: begin
            // delete only when the last parameter stored in this sequence is a '3'
            if (b == CH_TILDE && param_cnt != 0 && last_param == CH_DIGIT3)
              r.key_event = KEY_DELETE;
          end
        endcase
        seq_mode = SEEK_IDLE;
      end else begin
        seq_mode = SEEK_IDLE;
      end
    end else begin
      seq_mode = SEEK_IDLE;
    end
    return r;
  endfunction

  function automatic int pause_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit pinned = 1'b0,
                           input csip_result_t pinned_res = '0);
    csip_result_t predicted;
    bit           was_idle;
    int           gap;
    was_idle  = (seq_mode == SEEK_IDLE);
    predicted = parse_byte(b);
    pending_results.push_back(pinned ? pinned_res : predicted);
    // idle bytes that are just dropped do not count as real traffic
    if (!(was_idle && predicted.status == ST_DISCARDED)) fed_items++;
    in_valid <= 1'b1;
    ch       <= b;
    do @(posedge clk); while (!in_ready);
    gap = feed_calm ? 0 : pause_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
      repeat (gap) @(posedge clk);
    end else begin
      valid_up = 1'b1;
    end
  endtask

  task automatic idle_sender();
    if (valid_up) begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_sequence();
    int         n_params;
    logic [7:0] b;
    send_byte(CH_ESC);
    send_byte(CH_LBRACKET);
    // now and then run right up to and past the parameter limit
    if ($urandom_range(0, 19) == 0) n_params = $urandom_range(MAX_PARAMS - 1, MAX_PARAMS + 2);
    else n_params = $urandom_range(0, 3);
    for (int i = 0; i < n_params; i++) begin
      if (i == n_params - 1 && $urandom_range(0, 2) == 0) b = CH_DIGIT3;
      else b = 8'($urandom_range(CH_PARAM_LO, CH_PARAM_HI));
      send_byte(b);
    end
    case ($urandom_range(0, 5))
      0:       b = CH_UP;
      1:       b = CH_DOWN;
      2:       b = CH_RIGHT;
      3:       b = CH_LEFT;
      4:       b = CH_TILDE;
      default: b = 8'($urandom_range(CH_FINAL_LO, CH_FINAL_HI));
    endcase
    send_byte(b);
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 2))
      0: send_byte(8'($urandom_range(0, 255)));
      1: begin
        send_byte(CH_ESC);
        send_byte(8'($urandom_range(0, 255)));
      end
      default: begin
        send_byte(CH_ESC);
        send_byte(CH_LBRACKET);
        repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(CH_PARAM_LO, CH_PARAM_HI)));
        send_byte(8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  // result side: score each beat and stall at random
  initial begin : result_sink
    int           stall;
    bit           sink_calm;
    csip_result_t want;
    stall     = 0;
    sink_calm = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result beat with nothing expected: status %0d key_event %0d",
                 status, key_event);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            mismatches++;
          end
          if (key_event !== want.key_event) begin
            $error("key_event: expected %0d, got %0d", want.key_event, key_event);
            mismatches++;
          end
        end
      end
      if ($urandom_range(0, 299) == 0) sink_calm = !sink_calm;
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!sink_calm) stall = pause_len();
      end
    end
  end

  initial begin
    bit drained;
    seq_mode   = SEEK_IDLE;
    param_cnt  = 0;
    last_param = 8'h00;
    mismatches = 0;
    fed_items  = 0;
    valid_up   = 1'b0;
    feed_calm  = 1'b0;
    drained    = 1'b0;
    rst        = 1'b1;
    in_valid   = 1'b0;
    ch         = 8'h00;

    dir_rows = '{
      '{8'h00,       1'b1, ST_DISCARDED, KEY_UNDEFINED},
      '{8'hFF,       1'b1, ST_DISCARDED, KEY_UNDEFINED},
      '{CH_ESC,      1'b1, ST_CONSUMED,  KEY_UNDEFINED},
      '{CH_LBRACKET, 1'b1, ST_CONSUMED,  KEY_UNDEFINED},
      '{CH_UP,       1'b1, ST_COMPLETED, KEY_UP},
      '{CH_ESC,      1'b0, ST_DISCARDED, KEY_UNDEFINED},
      '{CH_LBRACKET, 1'b0, ST_DISCARDED, KEY_UNDEFINED},
      '{CH_DIGIT3,   1'b0, ST_DISCARDED, KEY_UNDEFINED},
      '{CH_TILDE,    1'b1, ST_COMPLETED, KEY_DELETE},
      // tilde with nothing stored, although the old '3' is still held
      '{CH_ESC,      1'b0, ST_DISCARDED, KEY_UNDEFINED},
      '{CH_LBRACKET, 1'b0, ST_DISCARDED, KEY_UNDEFINED},
      '{CH_TILDE,    1'b1, ST_COMPLETED, KEY_UNDEFINED},
      // second esc does not restart the sequence
      '{CH_ESC,      1'b0, ST_DISCARDED, KEY_UNDEFINED},
      '{CH_ESC,      1'b1, ST_DISCARDED, KEY_UNDEFINED},
      '{CH_ESC,      1'b0, ST_DISCARDED, KEY_UNDEFINED},
      '{8'h78,       1'b1, ST_DISCARDED, KEY_UNDEFINED},
      '{CH_ESC,      1'b0, ST_DISCARDED, KEY_UNDEFINED},
      '{CH_LBRACKET, 1'b0, ST_DISCARDED, KEY_UNDEFINED},
      '{CH_PARAM_LO, 1'b0, ST_DISCARDED, KEY_UNDEFINED},
      '{CH_PARAM_HI, 1'b0, ST_DISCARDED, KEY_UNDEFINED},
      '{CH_FINAL_LO, 1'b0, ST_DISCARDED, KEY_UNDEFINED},
      '{CH_ESC,      1'b0, ST_DISCARDED, KEY_UNDEFINED},
      '{CH_LBRACKET, 1'b0, ST_DISCARDED, KEY_UNDEFINED},
      '{8'h7F,       1'b1, ST_DISCARDED, KEY_UNDEFINED}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_byte(dir_rows[i].b, dir_rows[i].pinned, '{dir_rows[i].st, dir_rows[i].key});

    fed_items = 0;
    while (fed_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 39) == 0) feed_calm = !feed_calm;
      if ($urandom_range(0, 3) == 0) send_noise();
      else send_sequence();
      if (!drained && fed_items >= RANDOM_ITEMS / 2) begin
        // hold off until the output side has caught up completely
        idle_sender();
        while (pending_results.size() != 0) @(posedge clk);
        drained = 1'b1;
      end
    end

    idle_sender();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #8_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/csip_pkg.sv
rtl/csip_parser.sv
rtl/csip_out_reg.sv
rtl/csi_escape_sequence_parser_core.sv
rtl/csip_checker.sv
verif/csi_escape_sequence_parser_core_tb.sv
